// ----- rtl/differential_drive_mixer_core_macros.svh -----
// assertion macros shared by the checker
`ifndef DIFFERENTIAL_DRIVE_MIXER_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_MIXER_CORE_MACROS_SVH

// property checked only while reset is low
`define DDM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define DDM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ddm_pkg.sv -----
// types, constants and helper functions of the drive mixer
package ddm_pkg;

   localparam int REM_W     = 8;            // remainder, below the divisor
   localparam int DEN_W     = 9;            // divisor |sx|+|sy|, up to 256
   localparam int NUM_W     = 15;           // dividend m*|s|, up to 16384
   localparam int NUM_CELLS = NUM_W;        // one quotient bit per cell
   localparam int LATENCY   = NUM_CELLS + 4;

   localparam int MAG_W     = 14;           // |stick * percent|
   localparam int RECIP_W   = 13;
   localparam int RECIP_SH  = 19;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;  // ceil(2^19 / 100)

   localparam logic [6:0] YAW_RESET   = 7'd50;
   localparam logic [6:0] SPEED_RESET = 7'd100;

   localparam logic [0:0] CSR_YAW   = 1'b0;
   localparam logic [0:0] CSR_SPEED = 1'b1;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [NUM_W-1:0] nq;     // dividend bits shift out, quotient bits shift in
   } div_lane_type;

   typedef struct packed {
      logic             valid;
      div_lane_type     lane_x;
      div_lane_type     lane_y;
      logic [DEN_W-1:0] den;
      logic             neg_x;
      logic             neg_y;
   } div_word_type;

   // exact for n below 43690
   function automatic logic [7:0] div100(input logic [MAG_W-1:0] n);
      logic [MAG_W+RECIP_W-1:0] prod;
      prod = (MAG_W+RECIP_W)'(n) * (MAG_W+RECIP_W)'(RECIP_100);
      return prod[MAG_W+RECIP_W-1:RECIP_SH];
   endfunction

   function automatic logic signed [7:0] clamp8(input logic signed [9:0] v);
      logic signed [7:0] r;
      if (v > 10'sd127) begin
         r = 8'sd127;
      end else if (v < -10'sd128) begin
         r = -8'sd128;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   // one restoring division step
   function automatic div_lane_type div_step(input div_lane_type l,
                                             input logic [DEN_W-1:0] den);
      div_lane_type     r;
      logic [DEN_W-1:0] t;
      t = {l.rem, l.nq[NUM_W-1]};
      if (t >= den) begin
         r.rem = REM_W'(t - den);
         r.nq  = {l.nq[NUM_W-2:0], 1'b1};
      end else begin
         r.rem = t[REM_W-1:0];
         r.nq  = {l.nq[NUM_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ----- rtl/ddm_div_cell.sv -----
// one cell of the divider chain: one quotient bit for both lanes
module ddm_div_cell
   import ddm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_word_type word_i,
   output div_word_type word_o
);

   logic         valid_ff;
   div_word_type data_ff;
   div_word_type data_in;

   always_comb begin
      data_in        = word_i;
      data_in.lane_x = div_step(word_i.lane_x, word_i.den);
      data_in.lane_y = div_step(word_i.lane_y, word_i.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= word_i.valid;
      end
      data_ff <= data_in;
   end

   always_comb begin
      word_o       = data_ff;
      word_o.valid = valid_ff;
   end

endmodule

// ----- rtl/ddm_front.sv -----
// scaling by the percent registers and set-up of the mixing division
module ddm_front
   import ddm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic signed [7:0] stick_x,
   input  logic signed [7:0] stick_y,
   input  logic [6:0]        yaw_percent,
   input  logic [6:0]        speed_percent,
   output div_word_type      word_o
);

   // stage 1: products
   logic [15:0]      px, py;
   logic             v1_ff;
   logic             nx1_ff, ny1_ff;
   logic [MAG_W-1:0] mx1_ff, my1_ff;

   assign px = {{8{stick_x[7]}}, stick_x} * {9'd0, yaw_percent};
   assign py = {{8{stick_y[7]}}, stick_y} * {9'd0, speed_percent};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= take;
      end
      nx1_ff <= px[15];
      ny1_ff <= py[15];
      mx1_ff <= px[15] ? MAG_W'(-px) : px[MAG_W-1:0];
      my1_ff <= py[15] ? MAG_W'(-py) : py[MAG_W-1:0];
   end

   // stage 2: divide by 100, negate x, saturate
   logic signed [9:0] qx_ext, qy_ext;
   logic signed [7:0] sx_in, sy_in, sx_ff, sy_ff;
   logic              v2_ff;

   assign qx_ext = {2'b00, div100(mx1_ff)};
   assign qy_ext = {2'b00, div100(my1_ff)};
   assign sx_in  = clamp8(nx1_ff ? qx_ext : -qx_ext);
   assign sy_in  = clamp8(ny1_ff ? -qy_ext : qy_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      sx_ff <= sx_in;
      sy_ff <= sy_in;
   end

   // stage 3: magnitudes, larger one and numerators
   logic [7:0]       ax, ay, mm;
   logic             zero_x;
   logic [15:0]      numx, numy;
   logic             v3_ff;
   div_word_type     w3_ff;
   div_word_type     w3_in;

   assign ax     = sx_ff[7] ? (~sx_ff + 8'd1) : sx_ff;
   assign ay     = sy_ff[7] ? (~sy_ff + 8'd1) : sy_ff;
   assign mm     = (ax > ay) ? ax : ay;
   assign zero_x = (sx_ff == 8'sd0);
   assign numx   = 16'(mm) * 16'(ax);
   assign numy   = 16'(mm) * 16'(ay);

   // zero x passes y through as y/1
   always_comb begin
      w3_in            = '0;
      w3_in.lane_x.rem = '0;
      w3_in.lane_y.rem = '0;
      w3_in.lane_x.nq  = zero_x ? '0 : numx[NUM_W-1:0];
      w3_in.lane_y.nq  = zero_x ? NUM_W'(ay) : numy[NUM_W-1:0];
      w3_in.den        = zero_x ? DEN_W'(1) : (DEN_W'(ax) + DEN_W'(ay));
      w3_in.neg_x      = sx_ff[7];
      w3_in.neg_y      = sy_ff[7];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      w3_ff <= w3_in;
   end

   always_comb begin
      word_o       = w3_ff;
      word_o.valid = v3_ff;
   end

endmodule

// ----- rtl/differential_drive_mixer_core.sv -----
// strobe rises when a taken sample leaves the output register, behind the
// scaling stages and the divider cells; the word comes out with it.
// throughput: one sample per cycle out of reset; three scaling stages, fifteen
// divider cells (one quotient bit each) and an output register, all pipelined.
// busy follows reset, so nothing is taken while reset is high.
// reset clears all stage valids and loads yaw 50 and speed 100 percent.
module differential_drive_mixer_core
   import ddm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic signed [7:0] req_stick_x,
   input  logic signed [7:0] req_stick_y,
   output logic              strobe,
   output logic signed [7:0] rsp_left_power,
   output logic signed [7:0] rsp_right_power,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [6:0]        csr_wdata
);

   logic [6:0] yaw_ff, speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_ff   <= YAW_RESET;
         speed_ff <= SPEED_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_YAW:   yaw_ff   <= csr_wdata;
            CSR_SPEED: speed_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = reset;

   div_word_type chain [0:NUM_CELLS];

   ddm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (start && !busy),
      .stick_x      (req_stick_x),
      .stick_y      (req_stick_y),
      .yaw_percent  (yaw_ff),
      .speed_percent(speed_ff),
      .word_o       (chain[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      ddm_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .word_i(chain[i]),
         .word_o(chain[i+1])
      );
   end

   // sign the quotients, form the wheel powers
   logic signed [9:0] ox, oy;
   logic signed [7:0] left_in, right_in, left_ff, right_ff;
   logic              strobe_ff;

   assign ox = chain[NUM_CELLS].neg_x ? -{2'b00, chain[NUM_CELLS].lane_x.nq[7:0]}
                                      :  {2'b00, chain[NUM_CELLS].lane_x.nq[7:0]};
   assign oy = chain[NUM_CELLS].neg_y ? -{2'b00, chain[NUM_CELLS].lane_y.nq[7:0]}
                                      :  {2'b00, chain[NUM_CELLS].lane_y.nq[7:0]};
   assign left_in  = clamp8(oy + ox);
   assign right_in = clamp8(oy - ox);

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= chain[NUM_CELLS].valid;
      end
      left_ff  <= left_in;
      right_ff <= right_in;
   end

   assign strobe          = strobe_ff;
   assign rsp_left_power  = left_ff;
   assign rsp_right_power = right_ff;

endmodule

// ----- rtl/ddm_checker.sv -----
// port-level checks of the drive mixer, bound to the top level
`include "differential_drive_mixer_core_macros.svh"

module ddm_checker
   import ddm_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic signed [7:0] req_stick_x,
   input logic signed [7:0] req_stick_y,
   input logic              strobe,
   input logic signed [7:0] rsp_left_power,
   input logic signed [7:0] rsp_right_power
);

   logic centered;
   logic rest_ok;

   assign centered = (req_stick_x == 8'sd0) && (req_stick_y == 8'sd0);
   // a strobed word of a centered stick has both wheels stopped
   assign rest_ok  = !strobe || (rsp_left_power == 8'sd0 && rsp_right_power == 8'sd0);

   `DDM_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !strobe, "strobe right after reset")
   `DDM_ASSERT_ALWAYS(a_busy_in_reset, clock, reset |-> busy, "not busy during reset")
   `DDM_ASSERT(a_word_out, clock, reset, (start && !busy) |-> ##LATENCY strobe, "word lost")
   `DDM_ASSERT(a_no_extra, clock, reset, !(start && !busy) |-> ##LATENCY !strobe, "extra word")
   `DDM_ASSERT(a_center, clock, reset, $past(centered, LATENCY) |-> rest_ok, "centered moves")

endmodule

bind differential_drive_mixer_core ddm_checker u_ddm_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_stick_x    (req_stick_x),
   .req_stick_y    (req_stick_y),
   .strobe         (strobe),
   .rsp_left_power (rsp_left_power),
   .rsp_right_power(rsp_right_power)
);

// ----- tb/sv/differential_drive_mixer_core_test.sv -----
// self-checking testbench of the joystick to wheel power mixer core
module differential_drive_mixer_core_test;
   import ddm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERCENT_SCALE  = 100;
   localparam int MAX_GAP        = 13;
   localparam int WATCHDOG_LIMIT = 400;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_SAMPLES  = 76;

   typedef struct {
      logic signed [7:0] left;
      logic signed [7:0] right;
   } power_pair_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic signed [7:0] req_stick_x = '0;
   logic signed [7:0] req_stick_y = '0;
   logic              strobe;
   logic signed [7:0] rsp_left_power;
   logic signed [7:0] rsp_right_power;
   logic              csr_we = 1'b0;
   logic [0:0]        csr_index = CSR_YAW;
   logic [6:0]        csr_wdata = '0;

   logic [6:0]     yaw_pct = YAW_RESET;
   logic [6:0]     speed_pct = SPEED_RESET;
   power_pair_type power_expect[$];
   int             mismatches = 0;
   int             max_gap = MAX_GAP;
   int             idle_cycles = 0;

   differential_drive_mixer_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_stick_x     (req_stick_x),
      .req_stick_y     (req_stick_y),
      .strobe          (strobe),
      .rsp_left_power  (rsp_left_power),
      .rsp_right_power (rsp_right_power),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic int sat_byte(input int v);
      if (v > 127) begin
         return 127;
      end else if (v < -128) begin
         return -128;
      end
      return v;
   endfunction

   // arcade mix of one sample under the current percentages
   function automatic power_pair_type mix_power(input logic signed [7:0] x,
                                                input logic signed [7:0] y);
      power_pair_type p;
      int sx, sy, ax, ay, m, ox, oy;
      sx = sat_byte(-((int'(x) * int'(yaw_pct)) / PERCENT_SCALE));
      sy = sat_byte((int'(y) * int'(speed_pct)) / PERCENT_SCALE);
      if (sx == 0) begin
         ox = sx;
         oy = sy;
      end else begin
         ax = (sx < 0) ? -sx : sx;
         ay = (sy < 0) ? -sy : sy;
         m  = (ax > ay) ? ax : ay;
         ox = (m * sx) / (ax + ay);
         oy = (m * sy) / (ax + ay);
      end
      p.left  = 8'(sat_byte(oy + ox));
      p.right = 8'(sat_byte(oy - ox));
      return p;
   endfunction

   function automatic logic signed [7:0] pick_axis();
      case ($urandom_range(0, 7))
         0: return -8'sd128;
         1: return 8'sd127;
         2: return 8'(int'($urandom_range(0, 6)) - 3);
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task automatic send_sample(input logic signed [7:0] x, input logic signed [7:0] y);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_stick_x <= x;
      req_stick_y <= y;
      do @(posedge clock); while (busy);
      power_expect.push_back(mix_power(x, y));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (power_expect.size() != 0) @(posedge clock);
   endtask

   // both registers in back-to-back writes, block idle
   task automatic set_percentages(input logic [6:0] yaw, input logic [6:0] speed);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_YAW;
      csr_wdata <= yaw;
      @(posedge clock);
      yaw_pct   = yaw;
      csr_index <= CSR_SPEED;
      csr_wdata <= speed;
      @(posedge clock);
      speed_pct = speed;
      csr_we    <= 1'b0;
   endtask

   task automatic test_reset_percentages();
      send_sample(8'sd0, 8'sd0);
      send_sample(8'sd127, 8'sd127);
      send_sample(-8'sd128, -8'sd128);
      send_sample(-8'sd128, 8'sd127);
      send_sample(8'sd127, -8'sd128);
      send_sample(8'sd60, 8'sd0);
   endtask

   task automatic test_full_scale();
      set_percentages(7'd100, 7'd100);
      send_sample(-8'sd128, 8'sd0);
      send_sample(-8'sd128, -8'sd128);
      send_sample(-8'sd50, 8'sd50);
      send_sample(8'sd50, 8'sd50);
      send_sample(8'sd1, -8'sd1);
      send_sample(-8'sd90, 8'sd0);
   endtask

   task automatic test_over_scale();
      set_percentages(7'd127, 7'd127);
      send_sample(-8'sd128, 8'sd127);
      send_sample(8'sd127, -8'sd128);
      send_sample(8'sd127, 8'sd127);
      send_sample(-8'sd128, -8'sd128);
      send_sample(8'sd100, 8'sd0);
   endtask

   task automatic test_zero_scale();
      set_percentages(7'd0, 7'd0);
      send_sample(8'sd127, -8'sd128);
      set_percentages(7'd0, 7'd127);
      send_sample(8'sd127, 8'sd127);
      set_percentages(7'd127, 7'd0);
      send_sample(-8'sd128, -8'sd128);
      send_sample(8'sd1, 8'sd127);
   endtask

   task automatic test_random_mix();
      logic [6:0] yaw, speed;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin yaw = 7'd0;   speed = 7'd127; end
            1: begin yaw = 7'd127; speed = 7'd0;   end
            2: begin yaw = 7'd100; speed = 7'd100; end
            3: begin yaw = 7'd1;   speed = 7'd1;   end
            default: begin
               yaw   = 7'($urandom_range(0, 127));
               speed = 7'($urandom_range(0, 127));
            end
         endcase
         set_percentages(yaw, speed);
         // some phases run back to back with no sender gaps
         max_gap = (phase == 2 || phase == 5) ? 0 : MAX_GAP;
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            if (n == PHASE_SAMPLES / 2) begin
               drain_results();
            end
            send_sample(pick_axis(), pick_axis());
         end
         max_gap = MAX_GAP;
      end
   endtask

   always @(posedge clock) begin : check_words
      power_pair_type want;
      if (!reset && strobe) begin
         if (power_expect.size() == 0) begin
            report_mismatch($sformatf("unexpected word left %0d right %0d",
                                      rsp_left_power, rsp_right_power));
         end else begin
            want = power_expect.pop_front();
            if (rsp_left_power !== want.left) begin
               report_mismatch($sformatf("left_power %0d, want %0d",
                                         rsp_left_power, want.left));
            end
            if (rsp_right_power !== want.right) begin
               report_mismatch($sformatf("right_power %0d, want %0d",
                                         rsp_right_power, want.right));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || strobe || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_percentages();
      test_full_scale();
      test_over_scale();
      test_zero_scale();
      test_random_mix();
      drain_results();
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatches == 0 && power_expect.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
